>>> rtl/bsc_pkg.sv
// Package for the barometric sensor compensation block.
// Holds the payload and calibration types, the constants and helper functions.
// No dependencies.
package bsc_pkg;

    localparam int UP_W          = 19;
    localparam int DIV_W         = 32;
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [31:0] T_OFFSET   = 32'd4000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] PRS_SCALE  = 32'd50000;
    localparam logic [31:0] P_SQ_COEF  = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] P_OFFSET   = 32'd3791;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIB_A = 2'd0,
        CFG_CALIB_B = 2'd1,
        CFG_CALIB_C = 2'd2,
        CFG_OSS     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic [15:0]     ut;
        logic [UP_W-1:0] up;
        logic [1:0]      oss;
    } t_mid_item;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
    } t_calib;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

>>> rtl/bsc_fifo.sv
// Small synchronous queue with a flip-flop store and a combinational head.
// Depends on nothing but its parameters.
module bsc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

>>> rtl/bsc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a side-band word and a valid bit alongside; no package use.
module bsc_div #(
    parameter int W   = 32,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [W-1:0]   i_num,
    input  logic [W-1:0]   i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_vld,
    output logic [W-1:0]   o_quo,
    output logic [SBW-1:0] o_sb
);
    logic [W-1:0]   r_rem [W];
    logic [W-1:0]   r_nq  [W];
    logic [W-1:0]   r_den [W];
    logic [SBW-1:0] r_sb  [W];
    logic [W-1:0]   r_vld;

    logic [W-1:0]   n_rem [W];
    logic [W-1:0]   n_nq  [W];

    always_comb begin
        logic [W-1:0] p_rem, p_nq, p_den;
        logic [W:0]   rsh;
        for (int k = 0; k < W; k++) begin
            p_rem = (k == 0) ? '0    : r_rem[(k == 0) ? 0 : k - 1];
            p_nq  = (k == 0) ? i_num : r_nq[(k == 0) ? 0 : k - 1];
            p_den = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            rsh   = {p_rem, p_nq[W-1]};
            if (rsh >= {1'b0, p_den}) begin
                n_rem[k] = W'(rsh - {1'b0, p_den});
                n_nq[k]  = {p_nq[W-2:0], 1'b1};
            end else begin
                n_rem[k] = rsh[W-1:0];
                n_nq[k]  = {p_nq[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
                r_sb[k]  <= (k == 0) ? i_sb  : r_sb[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_vld = r_vld[W-1];
    assign o_quo = r_nq[W-1];
    assign o_sb  = r_sb[W-1];
endmodule

>>> rtl/bsc_front.sv
// Front end: takes input requests, aligns the pressure word to the oversampling
// setting and hands the request to the middle queue. Uses bsc_pkg.
module bsc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bsc_pkg::t_in_item   i_item,
    input  logic [1:0]          i_oss,
    output logic                o_full,
    output logic                o_mid_push,
    output bsc_pkg::t_mid_item  o_mid_item,
    input  logic                i_mid_full
);
    logic               r_vld;
    bsc_pkg::t_mid_item r_item;
    bsc_pkg::t_mid_item n_item;
    logic               accept;

    assign o_full     = r_vld && i_mid_full;
    assign accept     = i_push && !o_full;
    assign o_mid_push = r_vld;
    assign o_mid_item = r_item;

    always_comb begin
        n_item.ut  = i_item.raw_temperature;
        n_item.oss = i_oss;
        unique case (i_oss)
            2'd0:    n_item.up = bsc_pkg::UP_W'(i_item.raw_pressure[23:8]);
            2'd1:    n_item.up = bsc_pkg::UP_W'(i_item.raw_pressure[23:7]);
            2'd2:    n_item.up = bsc_pkg::UP_W'(i_item.raw_pressure[23:6]);
            default: n_item.up = bsc_pkg::UP_W'(i_item.raw_pressure[23:5]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (!i_mid_full) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end
endmodule

>>> rtl/bsc_back.sv
// Back end: the compensation pipeline with its two pipelined dividers.
// Uses bsc_pkg and bsc_div; pulls from the middle queue, pushes to the result queue.
module bsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsc_pkg::t_calib     i_cal,
    input  logic                i_mid_empty,
    input  bsc_pkg::t_mid_item  i_mid_item,
    output logic                o_mid_pop,
    output logic                o_out_push,
    output bsc_pkg::t_out_item  o_out_item,
    input  logic                i_out_full
);
    localparam int DW   = bsc_pkg::DIV_W;
    localparam int UW   = bsc_pkg::UP_W;
    localparam int SB1W = 32 + UW + 2 + 1 + 1;
    localparam int SB2W = 16 + 1 + 1;

    logic adv;

    // Stage registers; valid bits carry the control.
    logic r_v0, r_v1, r_v2, r_vd1, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic r_vd2, r_v12, r_v13, r_v14;

    logic [31:0]   r0_d;     logic [UW-1:0] r0_up;   logic [1:0] r0_oss;
    logic [31:0]   r1_m;     logic [UW-1:0] r1_up;   logic [1:0] r1_oss;
    logic [31:0]   r2_x1;    logic [UW-1:0] r2_up;   logic [1:0] r2_oss;
    logic [31:0]   r2_num, r2_den;  logic r2_fail, r2_neg;
    logic [31:0]   rd1_b5;   logic [UW-1:0] rd1_up;  logic [1:0] rd1_oss; logic rd1_fail;
    logic [31:0]   r4_b6;    logic [15:0] r4_t;  logic [UW-1:0] r4_up; logic [1:0] r4_oss;
    logic          r4_fail;
    logic [31:0]   r5_sqm, r5_a2, r5_a3;
    logic [15:0]   r5_t;     logic [UW-1:0] r5_up;   logic [1:0] r5_oss;  logic r5_fail;
    logic [31:0]   r6_sq, r6_x2a, r6_x1c;
    logic [15:0]   r6_t;     logic [UW-1:0] r6_up;   logic [1:0] r6_oss;  logic r6_fail;
    logic [31:0]   r7_b2sq, r7_b1sq, r7_x2a, r7_x1c;
    logic [15:0]   r7_t;     logic [UW-1:0] r7_up;   logic [1:0] r7_oss;  logic r7_fail;
    logic [31:0]   r8_xs, r8_b7p;
    logic [15:0]   r8_t;     logic [1:0] r8_oss;     logic r8_fail;
    logic [31:0]   r9_b4m, r9_b7p;
    logic [15:0]   r9_t;     logic [1:0] r9_oss;     logic r9_fail;
    logic [31:0]   r10_b4, r10_b7;
    logic [15:0]   r10_t;    logic r10_fail;
    logic [31:0]   rd2_p;    logic [15:0] rd2_t;     logic rd2_fail;
    logic [31:0]   r12_tt, r12_pm, r12_p;  logic [15:0] r12_t;  logic r12_fail;
    logic [31:0]   r13_tt3, r13_pm, r13_p; logic [15:0] r13_t;  logic r13_fail;
    bsc_pkg::t_out_item r14_out;

    // Sign-extended and zero-extended coefficients.
    logic [31:0] ac1x, ac2x, ac3x, ac4z, ac5z, ac6z, b1x, b2x, mcx, mdx;
    assign ac1x = bsc_pkg::sx16(i_cal.ac1);
    assign ac2x = bsc_pkg::sx16(i_cal.ac2);
    assign ac3x = bsc_pkg::sx16(i_cal.ac3);
    assign ac4z = {16'h0, i_cal.ac4};
    assign ac5z = {16'h0, i_cal.ac5};
    assign ac6z = {16'h0, i_cal.ac6};
    assign b1x  = bsc_pkg::sx16(i_cal.b1);
    assign b2x  = bsc_pkg::sx16(i_cal.b2);
    assign mcx  = bsc_pkg::sx16(i_cal.mc);
    assign mdx  = bsc_pkg::sx16(i_cal.md);

    assign adv        = !r_v14 || !i_out_full;
    assign o_mid_pop  = adv && !i_mid_empty;
    assign o_out_push = r_v14 && adv;
    assign o_out_item = r14_out;

    // Stage 2 combinational: first divisor and operand magnitudes.
    logic [31:0] s2_x1, s2_x2, s2_num;
    always_comb begin
        s2_x1  = bsc_pkg::asr32(r1_m, 15);
        s2_x2  = s2_x1 + mdx;
        s2_num = {mcx[20:0], 11'h0};
    end

    // First divider.
    logic [SB1W-1:0] d1_sb_in, d1_sb_out;
    logic [31:0]     d1_quo;
    logic            d1_vld;
    assign d1_sb_in = {r2_x1, r2_up, r2_oss, r2_fail, r2_neg};

    bsc_div #(.W(DW), .SBW(SB1W)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_v2),
        .i_num  (r2_num),
        .i_den  (r2_den),
        .i_sb   (d1_sb_in),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_sb   (d1_sb_out)
    );

    logic [31:0]   d1_x1, d1_q;
    logic [UW-1:0] d1_up;
    logic [1:0]    d1_oss;
    logic          d1_fail, d1_neg;
    always_comb begin
        {d1_x1, d1_up, d1_oss, d1_fail, d1_neg} = d1_sb_out;
        d1_q = d1_neg ? (32'h0 - d1_quo) : d1_quo;
    end

    // Stage 4: saturated temperature.
    logic [31:0] s4_t32;
    logic [15:0] s4_t;
    always_comb begin
        s4_t32 = bsc_pkg::asr32(rd1_b5 + 32'd8, 4);
        if ($signed(s4_t32) > 32'sd32767) begin
            s4_t = 16'h7FFF;
        end else if ($signed(s4_t32) < -32'sd32768) begin
            s4_t = 16'h8000;
        end else begin
            s4_t = s4_t32[15:0];
        end
    end

    // Stage 8: b3 and the b4 operand.
    logic [31:0] s8_x1, s8_x3, s8_b3, s8_x2, s8_x3p, s8_ac, s8_sh;
    always_comb begin
        s8_x1  = bsc_pkg::asr32(r7_b2sq, 11);
        s8_x3  = s8_x1 + r7_x2a;
        s8_ac  = {ac1x[29:0], 2'b00} + s8_x3;
        s8_sh  = s8_ac << r7_oss;
        s8_b3  = bsc_pkg::asr32(s8_sh + 32'd2, 2);
        s8_x2  = bsc_pkg::asr32(r7_b1sq, 16);
        s8_x3p = bsc_pkg::asr32(r7_x1c + s8_x2 + 32'd2, 2);
    end

    // Second divider: b7 is doubled before the divide when it fits, after otherwise.
    logic [SB2W-1:0] d2_sb_in, d2_sb_out;
    logic [31:0]     d2_num, d2_quo;
    logic            d2_vld, d2_post, d2_fail;
    logic [15:0]     d2_t;
    assign d2_num   = r10_b7[31] ? r10_b7 : {r10_b7[30:0], 1'b0};
    assign d2_sb_in = {r10_t, r10_fail, r10_b7[31]};

    bsc_div #(.W(DW), .SBW(SB2W)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_v10),
        .i_num  (d2_num),
        .i_den  (r10_b4),
        .i_sb   (d2_sb_in),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_sb   (d2_sb_out)
    );
    assign {d2_t, d2_fail, d2_post} = d2_sb_out;

    // Stage 14: final pressure correction.
    logic [31:0] s14_x1, s14_x2, s14_p;
    always_comb begin
        s14_x1 = bsc_pkg::asr32(r13_tt3, 16);
        s14_x2 = bsc_pkg::asr32(r13_pm, 16);
        s14_p  = r13_p + bsc_pkg::asr32(s14_x1 + s14_x2 + bsc_pkg::P_OFFSET, 4);
    end

    logic [31:0] s12_tw;
    assign s12_tw = bsc_pkg::asr32(rd2_p, 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0; r_v1  <= 1'b0; r_v2  <= 1'b0; r_vd1 <= 1'b0;
            r_v4  <= 1'b0; r_v5  <= 1'b0; r_v6  <= 1'b0; r_v7  <= 1'b0;
            r_v8  <= 1'b0; r_v9  <= 1'b0; r_v10 <= 1'b0; r_vd2 <= 1'b0;
            r_v12 <= 1'b0; r_v13 <= 1'b0; r_v14 <= 1'b0;
        end else if (adv) begin
            r_v0  <= !i_mid_empty;
            r_v1  <= r_v0;
            r_v2  <= r_v1;
            r_vd1 <= d1_vld;
            r_v4  <= r_vd1;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_vd2 <= d2_vld;
            r_v12 <= r_vd2;
            r_v13 <= r_v12;
            r_v14 <= r_v13;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_d   <= {16'h0, i_mid_item.ut} - ac6z;
            r0_up  <= i_mid_item.up;
            r0_oss <= i_mid_item.oss;

            r1_m   <= r0_d * ac5z;
            r1_up  <= r0_up;
            r1_oss <= r0_oss;

            r2_x1   <= s2_x1;
            r2_up   <= r1_up;
            r2_oss  <= r1_oss;
            r2_fail <= (s2_x2 == 32'h0);
            r2_neg  <= s2_num[31] ^ s2_x2[31];
            r2_num  <= s2_num[31] ? (32'h0 - s2_num) : s2_num;
            r2_den  <= s2_x2[31] ? (32'h0 - s2_x2) : s2_x2;

            rd1_b5   <= d1_x1 + d1_q;
            rd1_up   <= d1_up;
            rd1_oss  <= d1_oss;
            rd1_fail <= d1_fail;

            r4_b6   <= rd1_b5 - bsc_pkg::T_OFFSET;
            r4_t    <= s4_t;
            r4_up   <= rd1_up;
            r4_oss  <= rd1_oss;
            r4_fail <= rd1_fail;

            r5_sqm  <= r4_b6 * r4_b6;
            r5_a2   <= ac2x * r4_b6;
            r5_a3   <= ac3x * r4_b6;
            r5_t    <= r4_t;
            r5_up   <= r4_up;
            r5_oss  <= r4_oss;
            r5_fail <= r4_fail;

            r6_sq   <= bsc_pkg::asr32(r5_sqm, 12);
            r6_x2a  <= bsc_pkg::asr32(r5_a2, 11);
            r6_x1c  <= bsc_pkg::asr32(r5_a3, 13);
            r6_t    <= r5_t;
            r6_up   <= r5_up;
            r6_oss  <= r5_oss;
            r6_fail <= r5_fail;

            r7_b2sq <= b2x * r6_sq;
            r7_b1sq <= b1x * r6_sq;
            r7_x2a  <= r6_x2a;
            r7_x1c  <= r6_x1c;
            r7_t    <= r6_t;
            r7_up   <= r6_up;
            r7_oss  <= r6_oss;
            r7_fail <= r6_fail;

            r8_xs   <= s8_x3p + bsc_pkg::B4_BIAS;
            r8_b7p  <= {{(32 - UW){1'b0}}, r7_up} - s8_b3;
            r8_t    <= r7_t;
            r8_oss  <= r7_oss;
            r8_fail <= r7_fail;

            r9_b4m  <= ac4z * r8_xs;
            r9_b7p  <= r8_b7p;
            r9_t    <= r8_t;
            r9_oss  <= r8_oss;
            r9_fail <= r8_fail;

            r10_b4   <= r9_b4m >> 15;
            r10_b7   <= r9_b7p * (bsc_pkg::PRS_SCALE >> r9_oss);
            r10_t    <= r9_t;
            r10_fail <= r9_fail || ((r9_b4m >> 15) == 32'h0);

            rd2_p    <= d2_post ? {d2_quo[30:0], 1'b0} : d2_quo;
            rd2_t    <= d2_t;
            rd2_fail <= d2_fail;

            r12_tt   <= s12_tw * s12_tw;
            r12_pm   <= rd2_p * bsc_pkg::P_LIN_COEF;
            r12_p    <= rd2_p;
            r12_t    <= rd2_t;
            r12_fail <= rd2_fail;

            r13_tt3  <= r12_tt * bsc_pkg::P_SQ_COEF;
            r13_pm   <= r12_pm;
            r13_p    <= r12_p;
            r13_t    <= r12_t;
            r13_fail <= r12_fail;

            if (r13_fail) begin
                r14_out.temperature_tenths <= '0;
                r14_out.pressure_pa        <= '0;
                r14_out.status             <= 1'b1;
            end else begin
                r14_out.temperature_tenths <= r13_t;
                r14_out.pressure_pa        <= s14_p;
                r14_out.status             <= 1'b0;
            end
        end
    end
endmodule

>>> rtl/barometric_sensor_compensation.sv
// Top level of the barometric sensor compensation block.
// Uses bsc_pkg, bsc_front, bsc_fifo and bsc_back; holds the calibration registers.
//
//   Channel   Handshake          Payload
//   input     i_push / o_full    i_item   (bsc_pkg::t_in_item)
//   result    o_empty / i_pop    o_result (bsc_pkg::t_out_item)
//   config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// One request is taken every cycle while o_full is low; each result passes the front
// register, the middle queue, the back pipeline and the result queue on its way to
// the result ports. The two 32-stage dividers compute one quotient bit per stage.
// Reset is synchronous and active low; it empties the queues and loads the
// calibration words with zero and the oversampling setting with three.
// A full result queue stalls the back pipeline; the middle queue then fills
// and o_full rises.
module barometric_sensor_compensation #(
    parameter int MID_DEPTH = bsc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = bsc_pkg::OUT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  bsc_pkg::t_in_item                 i_item,
    output logic                              o_full,
    input  logic                              i_pop,
    output bsc_pkg::t_out_item                o_result,
    output logic                              o_empty,
    input  logic                              i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    logic [63:0] r_calib_a, r_calib_b;
    logic [31:0] r_calib_c;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_a <= '0;
            r_calib_b <= '0;
            r_calib_c <= '0;
            r_oss     <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (bsc_pkg::t_cfg_idx'(i_cfg_idx))
                bsc_pkg::CFG_CALIB_A: r_calib_a <= i_cfg_data;
                bsc_pkg::CFG_CALIB_B: r_calib_b <= i_cfg_data;
                bsc_pkg::CFG_CALIB_C: r_calib_c <= i_cfg_data[31:0];
                bsc_pkg::CFG_OSS:     r_oss     <= i_cfg_data[1:0];
                default:              r_oss     <= r_oss;
            endcase
        end
    end

    bsc_pkg::t_calib cal;
    always_comb begin
        cal.ac1 = r_calib_a[15:0];
        cal.ac2 = r_calib_a[31:16];
        cal.ac3 = r_calib_a[47:32];
        cal.ac4 = r_calib_a[63:48];
        cal.ac5 = r_calib_b[15:0];
        cal.ac6 = r_calib_b[31:16];
        cal.b1  = r_calib_b[47:32];
        cal.b2  = r_calib_b[63:48];
        cal.mc  = r_calib_c[15:0];
        cal.md  = r_calib_c[31:16];
    end

    logic                mid_push, mid_full, mid_pop, mid_empty;
    bsc_pkg::t_mid_item  mid_in, mid_out;
    logic                out_push, out_full;
    bsc_pkg::t_out_item  out_in;

    bsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_item    (i_item),
        .i_oss     (r_oss),
        .o_full    (o_full),
        .o_mid_push(mid_push),
        .o_mid_item(mid_in),
        .i_mid_full(mid_full)
    );

    bsc_fifo #(.W($bits(bsc_pkg::t_mid_item)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (mid_push),
        .i_data (mid_in),
        .o_full (mid_full),
        .i_pop  (mid_pop),
        .o_data (mid_out),
        .o_empty(mid_empty)
    );

    bsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cal      (cal),
        .i_mid_empty(mid_empty),
        .i_mid_item (mid_out),
        .o_mid_pop  (mid_pop),
        .o_out_push (out_push),
        .o_out_item (out_in),
        .i_out_full (out_full)
    );

    bsc_fifo #(.W($bits(bsc_pkg::t_out_item)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_in),
        .o_full (out_full),
        .i_pop  (i_pop),
        .o_data (o_result),
        .o_empty(o_empty)
    );
endmodule
